@@ rtl/core/wave_header_parser_unit_defines.svh @@
// Assertion macros of the wave header parser RTL.
`ifndef WAVE_HEADER_PARSER_UNIT_DEFINES_SVH
`define WAVE_HEADER_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define WHP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wave header parser: implication check failed");

// Whenever ante holds at a clock edge, cons must hold at the next edge.
`define WHP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wave header parser: next-cycle check failed");

`else

`define WHP_ASSERT_IMPLY(label, ante, cons)
`define WHP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/whp_pkg.sv @@
// Shared types and constants of the wave header parser.
`default_nettype none

package whp_pkg;

   // Field widths
   localparam int CLOCK_W    = 24;
   localparam int RATE_W     = 16;
   localparam int QUOT_LOW_W = 8;
   localparam int WORD_W     = 32;

   // Iterative divider: one quotient bit per step
   localparam int DIV_STEPS   = CLOCK_W;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

   // Reset value of the timer clock register
   localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 24'd2000000;

   // Result status codes
   localparam logic [1:0] STATUS_BUSY = 2'd0;
   localparam logic [1:0] STATUS_DATA = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   // Little-endian four-character ids
   localparam logic [WORD_W-1:0] TAG_WAVE = 32'h45564157;
   localparam logic [WORD_W-1:0] TAG_FMT  = 32'h20746D66;
   localparam logic [WORD_W-1:0] TAG_DATA = 32'h61746164;
   localparam logic [WORD_W-1:0] TAG_LIST = 32'h5453494C;
   localparam logic [WORD_W-1:0] TAG_FACT = 32'h74636166;

   // Header layout
   localparam logic [WORD_W-1:0] WAVE_ID_FIRST = 32'd8;
   localparam logic [WORD_W-1:0] WAVE_ID_END   = 32'd12;
   localparam logic [WORD_W-1:0] TAG_BYTES     = 32'd4;
   localparam logic [WORD_W-1:0] CHUNK_HDR_LEN = 32'd8;
   localparam logic [WORD_W-1:0] FMT_MIN_LEN   = 32'd16;
   localparam logic [WORD_W-1:0] FMT_MAX_LEN   = 32'd100;

   // Byte offsets inside a fmt body
   localparam logic [WORD_W-1:0] FMT_OFS_FORMAT   = 32'd0;
   localparam logic [WORD_W-1:0] FMT_OFS_CHANNELS = 32'd2;
   localparam logic [WORD_W-1:0] FMT_OFS_RATE_LO  = 32'd4;
   localparam logic [WORD_W-1:0] FMT_OFS_RATE_HI  = 32'd5;
   localparam logic [WORD_W-1:0] FMT_OFS_BITS     = 32'd14;

   // Accepted fmt values
   localparam logic [7:0] FORMAT_PCM = 8'd1;
   localparam logic [7:0] CH_MONO    = 8'd1;
   localparam logic [7:0] CH_STEREO  = 8'd2;
   localparam logic [7:0] BITS_8     = 8'd8;
   localparam logic [7:0] BITS_16    = 8'd16;

   // One input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
      logic       end_of_stream;
   } item_type;

   // One result item
   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] data_size;
      logic [7:0]        timer_top;
      logic [1:0]        channel_count;
      logic [4:0]        sample_bits;
   } result_type;

   // Parser handshake controls toward the top level
   typedef struct packed {
      logic ready;
      logic load;
   } prs_ctl_type;

   // Divider request and response
   typedef struct packed {
      logic               start;
      logic [CLOCK_W-1:0] dividend;
      logic [RATE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [QUOT_LOW_W-1:0] quotient_low;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/whp_div.sv @@
// Iterative restoring divider: timer clock over sample rate, one bit per cycle.
`default_nettype none

module whp_div (
   input  wire                  clock,
   input  wire                  reset,
   input  whp_pkg::div_req_type req,
   output whp_pkg::div_rsp_type rsp
);

   logic                                running_ff, running_in;
   logic                                done_ff, done_in;
   logic [whp_pkg::DIV_COUNT_W-1:0]     count_ff, count_in;
   logic [whp_pkg::RATE_W-1:0]          rem_ff, rem_in;
   logic [whp_pkg::CLOCK_W-1:0]         quo_ff, quo_in;
   logic [whp_pkg::RATE_W-1:0]          dvs_ff, dvs_in;
   logic [whp_pkg::RATE_W:0]            trial;
   logic [whp_pkg::RATE_W:0]            diff;
   logic                                fits;

   // Shared compare and subtract step
   assign trial = {rem_ff, quo_ff[whp_pkg::CLOCK_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   // Step sequencing
   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      if (req.start) begin
         running_in = 1'b1;
         count_in   = whp_pkg::DIV_COUNT_W'(whp_pkg::DIV_STEPS - 1);
         rem_in     = '0;
         quo_in     = req.dividend;
         dvs_in     = req.divisor;
      end else if (running_ff) begin
         rem_in = fits ? diff[whp_pkg::RATE_W-1:0] : trial[whp_pkg::RATE_W-1:0];
         quo_in = {quo_ff[whp_pkg::CLOCK_W-2:0], fits};
         if (count_ff == '0) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done         = done_ff;
   assign rsp.quotient_low = quo_ff[whp_pkg::QUOT_LOW_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/whp_parser.sv @@
// Byte-level header sequencer of the wave header parser.
`default_nettype none

module whp_parser (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          take,
   input  whp_pkg::item_type            item,
   input  wire [whp_pkg::CLOCK_W-1:0]   clock_hz,
   input  wire                          out_free,
   output whp_pkg::prs_ctl_type         ctl,
   output whp_pkg::result_type          result
);

   typedef enum logic [2:0] {
      PH_RIFF,
      PH_CHUNK,
      PH_FMT,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [whp_pkg::WORD_W-1:0]     pos_ff, pos_in;
   logic [whp_pkg::WORD_W-1:0]     pos_next;
   logic [whp_pkg::WORD_W-1:0]     tag_ff, tag_in;
   logic [whp_pkg::WORD_W-1:0]     len_ff, len_in;
   logic [7:0]                     fmt_ff, fmt_in;
   logic [1:0]                     ch_ff, ch_in;
   logic [4:0]                     bits_ff, bits_in;
   logic [whp_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [7:0]                     top_ff, top_in;
   logic [1:0]                     fin_ff, fin_in;
   logic [7:0]                     pend_ch_ff, pend_ch_in;
   logic [7:0]                     pend_bits_ff, pend_bits_in;
   logic                           busy_ff;
   logic                           pending_ff;
   logic                           div_go;
   whp_pkg::div_req_type           div_req;
   whp_pkg::div_rsp_type           div_rsp;

   // Shared divider for the timer top
   whp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign div_req.start    = take && div_go;
   assign div_req.dividend = clock_hz;
   assign div_req.divisor  = rate_in;

   // Next header state for the offered byte
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      fmt_in       = fmt_ff;
      ch_in        = ch_ff;
      bits_in      = bits_ff;
      rate_in      = rate_ff;
      top_in       = top_ff;
      fin_in       = fin_ff;
      pend_ch_in   = pend_ch_ff;
      pend_bits_in = pend_bits_ff;
      pos_next     = '0;
      div_go       = 1'b0;

      // New file: clear everything
      if (item.file_start) begin
         phase_in     = PH_RIFF;
         pos_in       = '0;
         tag_in       = '0;
         len_in       = '0;
         fmt_in       = '0;
         ch_in        = '0;
         bits_in      = '0;
         rate_in      = '0;
         top_in       = '0;
         fin_in       = whp_pkg::STATUS_BUSY;
         pend_ch_in   = '0;
         pend_bits_in = '0;
      end

      if (fin_in == whp_pkg::STATUS_BUSY) begin
         if (item.end_of_stream) begin
            fin_in   = whp_pkg::STATUS_BAD;
            phase_in = PH_DONE;
         end else begin
            pos_next = pos_in + 1'b1;
            unique case (phase_in)
               // Skip RIFF id and size, collect the WAVE id
               PH_RIFF: begin
                  if (pos_in >= whp_pkg::WAVE_ID_FIRST && pos_in < whp_pkg::WAVE_ID_END) begin
                     tag_in[{pos_in[1:0], 3'b000} +: 8] = item.data_byte;
                  end
                  pos_in = pos_next;
                  if (pos_in >= whp_pkg::WAVE_ID_END) begin
                     if (tag_in != whp_pkg::TAG_WAVE) begin
                        fin_in   = whp_pkg::STATUS_BAD;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_CHUNK;
                        pos_in   = '0;
                        tag_in   = '0;
                        len_in   = '0;
                     end
                  end
               end
               // Chunk header: id then size, then dispatch
               PH_CHUNK: begin
                  if (pos_in < whp_pkg::TAG_BYTES) begin
                     tag_in[{pos_in[1:0], 3'b000} +: 8] = item.data_byte;
                  end else if (pos_in < whp_pkg::CHUNK_HDR_LEN) begin
                     len_in[{pos_in[1:0], 3'b000} +: 8] = item.data_byte;
                  end
                  pos_in = pos_next;
                  if (pos_in >= whp_pkg::CHUNK_HDR_LEN) begin
                     priority if (tag_in == whp_pkg::TAG_FMT) begin
                        if (len_in > whp_pkg::FMT_MAX_LEN || len_in < whp_pkg::FMT_MIN_LEN) begin
                           fin_in   = whp_pkg::STATUS_BAD;
                           phase_in = PH_DONE;
                        end else begin
                           phase_in     = PH_FMT;
                           pos_in       = '0;
                           fmt_in       = '0;
                           pend_ch_in   = '0;
                           pend_bits_in = '0;
                           rate_in      = '0;
                        end
                     end else if (tag_in == whp_pkg::TAG_DATA) begin
                        fin_in   = whp_pkg::STATUS_DATA;
                        phase_in = PH_DONE;
                     end else if (tag_in == whp_pkg::TAG_LIST || tag_in == whp_pkg::TAG_FACT) begin
                        if (len_in == '0) begin
                           phase_in = PH_CHUNK;
                           pos_in   = '0;
                           tag_in   = '0;
                           len_in   = '0;
                        end else begin
                           phase_in = PH_SKIP;
                           pos_in   = '0;
                        end
                     end else begin
                        fin_in   = whp_pkg::STATUS_BAD;
                        phase_in = PH_DONE;
                     end
                  end
               end
               // fmt body: pick the fields, check at its end
               PH_FMT: begin
                  priority if (pos_in == whp_pkg::FMT_OFS_FORMAT) begin
                     fmt_in = item.data_byte;
                  end else if (pos_in == whp_pkg::FMT_OFS_CHANNELS) begin
                     pend_ch_in = item.data_byte;
                  end else if (pos_in == whp_pkg::FMT_OFS_RATE_LO) begin
                     rate_in[7:0] = item.data_byte;
                  end else if (pos_in == whp_pkg::FMT_OFS_RATE_HI) begin
                     rate_in[15:8] = item.data_byte;
                  end else if (pos_in == whp_pkg::FMT_OFS_BITS) begin
                     pend_bits_in = item.data_byte;
                  end else begin
                  end
                  pos_in = pos_next;
                  if (pos_in >= len_in) begin
                     if (fmt_in != whp_pkg::FORMAT_PCM
                         || (pend_ch_in != whp_pkg::CH_MONO && pend_ch_in != whp_pkg::CH_STEREO)
                         || (pend_bits_in != whp_pkg::BITS_8 && pend_bits_in != whp_pkg::BITS_16)
                         || rate_in == '0) begin
                        fin_in   = whp_pkg::STATUS_BAD;
                        phase_in = PH_DONE;
                     end else begin
                        ch_in    = pend_ch_in[1:0];
                        bits_in  = pend_bits_in[4:0];
                        div_go   = 1'b1;
                        phase_in = PH_CHUNK;
                        pos_in   = '0;
                        tag_in   = '0;
                        len_in   = '0;
                     end
                  end
               end
               // Skipped chunk body
               PH_SKIP: begin
                  pos_in = pos_next;
                  if (pos_in >= len_in) begin
                     phase_in = PH_CHUNK;
                     pos_in   = '0;
                     tag_in   = '0;
                     len_in   = '0;
                  end
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Handshake: hold off while dividing or while a result cannot move out
   assign ctl.ready = !busy_ff && (!pending_ff || out_free);
   assign ctl.load  = pending_ff && out_free;

   // State and result bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         pos_ff       <= '0;
         tag_ff       <= '0;
         len_ff       <= '0;
         fmt_ff       <= '0;
         ch_ff        <= '0;
         bits_ff      <= '0;
         rate_ff      <= '0;
         top_ff       <= '0;
         fin_ff       <= whp_pkg::STATUS_BUSY;
         pend_ch_ff   <= '0;
         pend_bits_ff <= '0;
         busy_ff      <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         if (take) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            tag_ff       <= tag_in;
            len_ff       <= len_in;
            fmt_ff       <= fmt_in;
            ch_ff        <= ch_in;
            bits_ff      <= bits_in;
            rate_ff      <= rate_in;
            top_ff       <= top_in;
            fin_ff       <= fin_in;
            pend_ch_ff   <= pend_ch_in;
            pend_bits_ff <= pend_bits_in;
            busy_ff      <= div_go;
            pending_ff   <= !div_go;
         end else if (ctl.load) begin
            pending_ff <= 1'b0;
         end
         // Quotient back: timer top is its low byte minus one
         if (div_rsp.done) begin
            top_ff     <= div_rsp.quotient_low - 1'b1;
            busy_ff    <= 1'b0;
            pending_ff <= 1'b1;
         end
      end
   end

   assign result.status        = fin_ff;
   assign result.data_size     = (fin_ff == whp_pkg::STATUS_DATA) ? len_ff : '0;
   assign result.timer_top     = top_ff;
   assign result.channel_count = ch_ff;
   assign result.sample_bits   = bits_ff;

endmodule

`default_nettype wire

@@ rtl/core/wave_header_parser_unit.sv @@
// Wave header parser top level: channels, timer clock register, result register.
//
// Usage:
//   req_* carries the file one byte per item; tuser flags a new file (bit 0)
//   or the end of the stream (bit 1). Every accepted item gives exactly one
//   result item on rsp_*: the parse status in tuser, and in tdata the data
//   chunk size, timer top, channel count and sample bits seen so far.
//   csr_wr_en/csr_wr_data set the timer input clock in Hz; write it only
//   while no item is in flight.
// Flow:
//   A byte is parsed at its accept edge into the parser state registers;
//   its result then moves into the output register once that is free.
//   Items flow at one per cycle while no divide runs and rsp_tready is high.
//   A byte that completes a valid fmt chunk starts the shared bit-serial
//   divider (24 steps); no item is taken until its quotient is back.
// Reset: synchronous, active high; parser state is cleared, the timer clock
//   register returns to 2 MHz and no result is offered.
// Stall: a result waits in the output register while rsp_tready is low; one
//   further item is still taken and parsed, then req_tready drops.
`default_nettype none
`include "wave_header_parser_unit_defines.svh"

module wave_header_parser_unit (
   input  wire         clock,
   input  wire         reset,
   // Input items
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  [1:0]  req_tuser,   // [0] file_start, [1] end_of_stream
   // Result items
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] data_size, [39:32] timer_top,
                                    // [41:40] channel_count, [46:42] sample_bits, [47] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Timer clock register
   input  wire         csr_wr_en,
   input  wire  [23:0] csr_wr_data
);

   logic [whp_pkg::CLOCK_W-1:0]  clock_hz_ff;
   logic                         rsp_valid_ff;
   whp_pkg::result_type          out_ff;
   whp_pkg::item_type            item;
   whp_pkg::prs_ctl_type         ctl;
   whp_pkg::result_type          result;
   logic                         out_free;
   logic                         take;

   assign item.data_byte     = req_tdata;
   assign item.file_start    = req_tuser[0];
   assign item.end_of_stream = req_tuser[1];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ctl.ready;
   assign take       = req_tvalid && ctl.ready;

   whp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .item     (item),
      .clock_hz (clock_hz_ff),
      .out_free (out_free),
      .ctl      (ctl),
      .result   (result)
   );

   // Timer clock register
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= whp_pkg::CLOCK_HZ_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.load) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {1'b0, out_ff.sample_bits, out_ff.channel_count,
                        out_ff.timer_top, out_ff.data_size};

   // A waiting result is never overwritten
   `WHP_ASSERT_IMPLY(a_no_overwrite, ctl.load && rsp_valid_ff, rsp_tready)
   // Size shows only with a found data chunk
   `WHP_ASSERT_IMPLY(a_size_only_data, rsp_valid_ff && out_ff.status != whp_pkg::STATUS_DATA,
                     out_ff.data_size == '0)
   // A seen fmt chunk carries a legal sample width
   `WHP_ASSERT_IMPLY(a_fmt_pair, rsp_valid_ff && out_ff.channel_count != 2'd0,
                     out_ff.sample_bits == 5'd8 || out_ff.sample_bits == 5'd16)
   // Status is one of the three defined codes
   `WHP_ASSERT_IMPLY(a_status_code, rsp_valid_ff,
                     out_ff.status == whp_pkg::STATUS_BUSY || out_ff.status == whp_pkg::STATUS_DATA
                     || out_ff.status == whp_pkg::STATUS_BAD)
   // After an accepted item its result moves out or the input is held off
   `WHP_ASSERT_NEXT(a_item_progress, take, ctl.load || !ctl.ready)

endmodule

`default_nettype wire
